/* rtl/core/stsl_pkg.sv */
// Shared types and constants of the straight-line segmenter.
package stsl_pkg;

    // Index counter width, default for the top-level parameter.
    localparam int INDEX_WIDTH_DEF = 24;

    // Field widths fixed by the interface.
    localparam int OUT_INDEX_W = 24;
    localparam int COUNT_W     = 25;
    localparam int GAP_W       = 17;
    localparam int MOVE_W      = 40;
    localparam int POS_W       = 32;
    localparam int HEAD_W      = 20;
    localparam int STEP_W      = 20;
    localparam int DEG_W       = 18;
    localparam int HWRAP_W     = 19;
    localparam int KCONST_W    = 22;
    localparam int HPROD_W     = HEAD_W + KCONST_W;
    localparam int CFG_IDX_W   = 2;

    // Radian to 1/256 degree scale: round(2^24 * 180 / pi / 256).
    localparam logic [KCONST_W-1:0] DEG_K = 22'd3754936;
    localparam logic [HPROD_W:0] DEG_ROUND = 43'd8388608;

    // 90, 270 and 360 degrees in units of 1/256 degree.
    localparam logic signed [DEG_W-1:0]   DEG_90  = 18'sd23040;
    localparam logic signed [DEG_W-1:0]   DEG_270 = 18'sd69120;
    localparam logic signed [HWRAP_W-1:0] DEG_360 = 19'sd92160;

    // Saturation point of the run length.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 25'd16777216;

    // Register reset values.
    localparam logic [GAP_W-1:0]   GAP_RST   = 17'd256;
    localparam logic [GAP_W-1:0]   RANGE_RST = 17'd1280;
    localparam logic [COUNT_W-1:0] MINPTS_RST = 25'd100;
    localparam logic [MOVE_W-1:0]  MOVE_RST  = 40'd105;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP    = 2'd0,
        CFG_RANGE  = 2'd1,
        CFG_MINPTS = 2'd2,
        CFG_MOVE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAP_W-1:0]   max_gap;
        logic [GAP_W-1:0]   max_range;
        logic [COUNT_W-1:0] min_pts;
        logic [MOVE_W-1:0]  min_move;
    } t_cfg;

    // After the step and heading magnitudes are taken.
    typedef struct packed {
        logic              big;
        logic [STEP_W-1:0] adx;
        logic [STEP_W-1:0] ady;
        logic [HEAD_W-1:0] habs;
        logic              hneg;
        logic              last;
    } t_step;

    // After the squares and the degree product.
    typedef struct packed {
        logic                big;
        logic [2*STEP_W-1:0] sqx;
        logic [2*STEP_W-1:0] sqy;
        logic [HPROD_W-1:0]  hprod;
        logic                hneg;
        logic                last;
    } t_sq;

    // Movement flag and signed heading in degrees.
    typedef struct packed {
        logic                    moving;
        logic signed [DEG_W-1:0] deg;
        logic                    last;
    } t_head;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] first_index;
        logic [OUT_INDEX_W-1:0] final_index;
        logic [COUNT_W-1:0]     point_count;
        logic                   last_of_run;
    } t_result;

    // Up to two results from one sample, old run first.
    typedef struct packed {
        logic    a_vld;
        t_result a;
        logic    b_vld;
        t_result b;
    } t_push;

endpackage

/* rtl/core/trajectory_straight_line_segmenter_unit.sv */
// Top level of the straight-line segmenter: registers, pipeline and result queue.
// A sample beat is registered in the front stages and the condition stage; the
// run tracker then writes its results to the four-entry result queue. Throughput:
// one sample per cycle while the queue has room; a sample's two results go in at once.
// Reset (synchronous, active low) clears the run state, index, queue and
// registers to their defaults; no clearing pass is needed.
module trajectory_straight_line_segmenter_unit #(
    parameter int INDEX_WIDTH = stsl_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [stsl_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [stsl_pkg::MOVE_W-1:0]             i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [stsl_pkg::POS_W-1:0]       i_x_pos,
    input  logic signed [stsl_pkg::POS_W-1:0]       i_y_pos,
    input  logic signed [stsl_pkg::HEAD_W-1:0]      i_heading_rad,
    input  logic                                    i_last_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [stsl_pkg::OUT_INDEX_W-1:0]        o_first_index,
    output logic [stsl_pkg::OUT_INDEX_W-1:0]        o_final_index,
    output logic [stsl_pkg::COUNT_W-1:0]            o_point_count,
    output logic                                    o_last_of_run
);

    stsl_pkg::t_cfg  r_cfg;
    stsl_pkg::t_sq   sq;
    stsl_pkg::t_head hd;
    stsl_pkg::t_push push;
    logic            sq_valid;
    logic            sq_ready;
    logic            hd_valid;
    logic            hd_ready;
    logic            room;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_gap   <= stsl_pkg::GAP_RST;
            r_cfg.max_range <= stsl_pkg::RANGE_RST;
            r_cfg.min_pts   <= stsl_pkg::MINPTS_RST;
            r_cfg.min_move  <= stsl_pkg::MOVE_RST;
        end else if (i_cfg_valid) begin
            case (stsl_pkg::t_cfg_idx'(i_cfg_index))
                stsl_pkg::CFG_GAP: begin
                    r_cfg.max_gap <= i_cfg_data[stsl_pkg::GAP_W-1:0];
                end
                stsl_pkg::CFG_RANGE: begin
                    r_cfg.max_range <= i_cfg_data[stsl_pkg::GAP_W-1:0];
                end
                stsl_pkg::CFG_MINPTS: begin
                    r_cfg.min_pts <= i_cfg_data[stsl_pkg::COUNT_W-1:0];
                end
                stsl_pkg::CFG_MOVE: begin
                    r_cfg.min_move <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Step magnitudes, squares and degree product.
    stsl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_heading_rad (i_heading_rad),
        .i_last_sample (i_last_sample),
        .o_dn_valid    (sq_valid),
        .i_dn_ready    (sq_ready),
        .o_dn          (sq)
    );

    // Movement test and signed degrees.
    stsl_cond u_cond (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (sq_valid),
        .o_up_ready (sq_ready),
        .i_up       (sq),
        .i_min_move (r_cfg.min_move),
        .o_dn_valid (hd_valid),
        .i_dn_ready (hd_ready),
        .o_dn       (hd)
    );

    // Run decisions and state.
    stsl_run #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (hd_valid),
        .o_up_ready (hd_ready),
        .i_up       (hd),
        .i_cfg      (r_cfg),
        .i_room     (room),
        .o_push     (push)
    );

    // Result queue feeding the output channel.
    stsl_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_room        (room),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_first_index (o_first_index),
        .o_final_index (o_final_index),
        .o_point_count (o_point_count),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* rtl/core/stsl_front.sv */
// Front stages: step and heading magnitudes, then squares and degree product.
module stsl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [stsl_pkg::POS_W-1:0]   i_x_pos,
    input  logic signed [stsl_pkg::POS_W-1:0]   i_y_pos,
    input  logic signed [stsl_pkg::HEAD_W-1:0]  i_heading_rad,
    input  logic                                i_last_sample,
    output logic                                o_dn_valid,
    input  logic                                i_dn_ready,
    output stsl_pkg::t_sq                       o_dn
);

    localparam int PW = stsl_pkg::POS_W;
    localparam int SW = stsl_pkg::STEP_W;
    localparam int HW = stsl_pkg::HEAD_W;

    logic                 r_v1;
    logic                 r_v2;
    stsl_pkg::t_step      r_s1;
    stsl_pkg::t_sq        r_s2;
    logic signed [PW-1:0] r_prev_x;
    logic signed [PW-1:0] r_prev_y;

    logic                 adv1;
    logic                 adv2;
    logic                 accept;
    logic signed [PW:0]   dx;
    logic signed [PW:0]   dy;
    logic [PW:0]          adx;
    logic [PW:0]          ady;
    stsl_pkg::t_step      n_s1;
    stsl_pkg::t_sq        n_s2;

    // Each stage moves on when it is empty or its contents move on.
    assign adv2       = !r_v2 || i_dn_ready;
    assign adv1       = !r_v1 || adv2;
    assign accept     = i_in_valid && adv1;
    assign o_in_ready = adv1;
    assign o_dn_valid = r_v2;
    assign o_dn       = r_s2;

    // Step against the previous sample, and magnitudes.
    always_comb begin
        dx  = {i_x_pos[PW-1], i_x_pos} - {r_prev_x[PW-1], r_prev_x};
        dy  = {i_y_pos[PW-1], i_y_pos} - {r_prev_y[PW-1], r_prev_y};
        adx = dx[PW] ? (PW+1)'(-dx) : dx;
        ady = dy[PW] ? (PW+1)'(-dy) : dy;
        n_s1.big  = (|adx[PW:SW]) || (|ady[PW:SW]);
        n_s1.adx  = adx[SW-1:0];
        n_s1.ady  = ady[SW-1:0];
        n_s1.hneg = i_heading_rad[HW-1];
        n_s1.habs = i_heading_rad[HW-1] ? HW'(-i_heading_rad) : i_heading_rad;
        n_s1.last = i_last_sample;
    end

    // Squares of the step and the radian to degree product.
    always_comb begin
        n_s2.big   = r_s1.big;
        n_s2.sqx   = r_s1.adx * r_s1.adx;
        n_s2.sqy   = r_s1.ady * r_s1.ady;
        n_s2.hprod = r_s1.habs * stsl_pkg::DEG_K;
        n_s2.hneg  = r_s1.hneg;
        n_s2.last  = r_s1.last;
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Previous position follows every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (accept) begin
            r_prev_x <= i_x_pos;
            r_prev_y <= i_y_pos;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (adv2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

endmodule

/* rtl/core/stsl_cond.sv */
// Condition stage: movement test and rounded signed heading in degrees.
module stsl_cond (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_up_valid,
    output logic                               o_up_ready,
    input  stsl_pkg::t_sq                      i_up,
    input  logic [stsl_pkg::MOVE_W-1:0]        i_min_move,
    output logic                               o_dn_valid,
    input  logic                               i_dn_ready,
    output stsl_pkg::t_head                    o_dn
);

    localparam int HP = stsl_pkg::HPROD_W;
    localparam int DW = stsl_pkg::DEG_W;
    localparam int MW = stsl_pkg::MOVE_W;

    logic             r_v;
    stsl_pkg::t_head  r_h;

    logic             adv;
    logic [MW:0]      sum_sq;
    logic [HP:0]      rnd;
    logic [DW-1:0]    mag;
    stsl_pkg::t_head  n_h;

    assign adv        = !r_v || i_dn_ready;
    assign o_up_ready = adv;
    assign o_dn_valid = r_v;
    assign o_dn       = r_h;

    // Moving when the step is large or its square reaches the limit;
    // degrees rounded half away from zero.
    always_comb begin
        sum_sq     = {1'b0, i_up.sqx} + {1'b0, i_up.sqy};
        n_h.moving = i_up.big || (sum_sq >= {1'b0, i_min_move});
        rnd        = {1'b0, i_up.hprod} + stsl_pkg::DEG_ROUND;
        mag        = {1'b0, rnd[HP-2:24]};
        n_h.deg    = i_up.hneg ? DW'(-$signed(mag)) : $signed(mag);
        n_h.last   = i_up.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_up_valid) begin
            r_h <= n_h;
        end
    end

endmodule

/* rtl/core/stsl_run.sv */
// Run tracker: heading checks, run state and the results a sample closes.
module stsl_run #(
    parameter int INDEX_WIDTH = stsl_pkg::INDEX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_up_valid,
    output logic             o_up_ready,
    input  stsl_pkg::t_head  i_up,
    input  stsl_pkg::t_cfg   i_cfg,
    input  logic             i_room,
    output stsl_pkg::t_push  o_push
);

    localparam int IW = INDEX_WIDTH;
    localparam int OW = stsl_pkg::OUT_INDEX_W;
    localparam int CW = stsl_pkg::COUNT_W;
    localparam int DW = stsl_pkg::DEG_W;
    localparam int WW = stsl_pkg::HWRAP_W;

    logic [IW-1:0]        r_counter;
    logic [IW-1:0]        r_first;
    logic [CW-1:0]        r_len;
    logic signed [DW-1:0] r_start;
    logic signed [WW-1:0] r_prev;

    logic                 fire;
    logic                 had_run;
    logic                 wrap;
    logic signed [WW-1:0] deg_w;
    logic signed [WW-1:0] ha;
    logic signed [WW:0]   d_gap;
    logic signed [WW:0]   d_rng;
    logic [WW:0]          a_gap;
    logic [WW:0]          a_rng;
    logic                 ok;
    logic                 open;
    logic [CW-1:0]        n_len;
    logic [IW-1:0]        n_first;
    logic [IW-1:0]        idx_m1;

    assign fire       = i_up_valid && i_room;
    assign o_up_ready = i_room;

    // Heading wrap and the three join conditions.
    always_comb begin
        had_run = (r_len != '0);
        deg_w   = WW'(i_up.deg);
        wrap    = (i_up.deg > stsl_pkg::DEG_270) && (r_start < stsl_pkg::DEG_90);
        ha      = wrap ? deg_w - stsl_pkg::DEG_360 : deg_w;
        d_gap   = (WW+1)'(ha) - (WW+1)'(r_prev);
        d_rng   = (WW+1)'(ha) - (WW+1)'(r_start);
        a_gap   = d_gap[WW] ? (WW+1)'(-d_gap) : d_gap;
        a_rng   = d_rng[WW] ? (WW+1)'(-d_rng) : d_rng;
        ok      = i_up.moving
                  && (a_gap < (WW+1)'(i_cfg.max_gap))
                  && (a_rng < (WW+1)'(i_cfg.max_range));
        open    = !had_run || !ok;
        if (open) begin
            n_len   = CW'(1);
            n_first = r_counter;
        end else begin
            n_len   = (r_len < stsl_pkg::COUNT_MAX) ? r_len + CW'(1) : r_len;
            n_first = r_first;
        end
        idx_m1 = r_counter - IW'(1);
    end

    // Results: the run this sample broke, then the run a last sample closes.
    always_comb begin
        o_push.b_vld = fire && i_up.last && (n_len >= i_cfg.min_pts);
        o_push.a_vld = fire && had_run && !ok && (r_len >= i_cfg.min_pts);
        o_push.a.first_index = OW'(r_first);
        o_push.a.final_index = OW'(idx_m1);
        o_push.a.point_count = r_len;
        o_push.a.last_of_run = !o_push.b_vld;
        o_push.b.first_index = OW'(n_first);
        o_push.b.final_index = OW'(r_counter);
        o_push.b.point_count = n_len;
        o_push.b.last_of_run = 1'b1;
    end

    // Run state update; a last sample clears the run and the index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_first   <= '0;
            r_len     <= '0;
            r_start   <= '0;
            r_prev    <= '0;
        end else if (fire) begin
            r_first <= n_first;
            if (open) begin
                r_start <= i_up.deg;
                r_prev  <= deg_w;
            end else begin
                r_prev  <= ha;
            end
            if (i_up.last) begin
                r_len     <= '0;
                r_counter <= '0;
            end else begin
                r_len     <= n_len;
                r_counter <= r_counter + IW'(1);
            end
        end
    end

endmodule

/* rtl/core/stsl_outq.sv */
// Result queue: four entries, takes up to two results a cycle, gives one.
module stsl_outq (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  stsl_pkg::t_push                         i_push,
    output logic                                    o_room,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [stsl_pkg::OUT_INDEX_W-1:0]        o_first_index,
    output logic [stsl_pkg::OUT_INDEX_W-1:0]        o_final_index,
    output logic [stsl_pkg::COUNT_W-1:0]            o_point_count,
    output logic                                    o_last_of_run
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = AW + 1;

    stsl_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [NW-1:0]     r_cnt;

    logic              pop;
    logic [NW-1:0]     n_push;
    stsl_pkg::t_result slot0;
    stsl_pkg::t_result head;

    // Room for a whole sample's results, whatever is popped this cycle.
    assign o_room      = (r_cnt <= NW'(DEPTH - 2));
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign head        = r_mem[r_rp];
    assign o_first_index = head.first_index;
    assign o_final_index = head.final_index;
    assign o_point_count = head.point_count;
    assign o_last_of_run = head.last_of_run;

    always_comb begin
        n_push = NW'(i_push.a_vld) + NW'(i_push.b_vld);
        slot0  = i_push.a_vld ? i_push.a : i_push.b;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(n_push);
            r_cnt <= r_cnt + n_push - NW'(pop);
            if (pop) begin
                r_rp <= r_rp + AW'(1);
            end
        end
    end

    // Entry writes; the second result lands behind the first.
    always_ff @(posedge i_clk) begin
        if (i_push.a_vld || i_push.b_vld) begin
            r_mem[r_wp] <= slot0;
        end
        if (i_push.a_vld && i_push.b_vld) begin
            r_mem[r_wp + AW'(1)] <= i_push.b;
        end
    end

endmodule
